// ----- rtl/abrf_pkg.sv -----
// Package with the command and mode codes, request/result types and bank decode functions.
`timescale 1ns / 1ps
`default_nettype none

package abrf_pkg;

	typedef enum logic [2:0] {
		CMD_READ       = 3'd0,
		CMD_WRITE      = 3'd1,
		CMD_WRITE_MODE = 3'd2,
		CMD_RD_CPSR    = 3'd3,
		CMD_WR_CPSR    = 3'd4,
		CMD_RD_SPSR    = 3'd5,
		CMD_WR_SPSR    = 3'd6,
		CMD_EXCEPTION  = 3'd7
	} cmd_t;

	// Bank selector values.
	typedef enum logic [2:0] {
		MODE_USR = 3'd0,
		MODE_FIQ = 3'd1,
		MODE_IRQ = 3'd2,
		MODE_SVC = 3'd3,
		MODE_ABT = 3'd4,
		MODE_UND = 3'd5,
		MODE_SYS = 3'd6,
		MODE_BAD = 3'd7
	} mode_t;

	// Architectural mode codes.
	localparam logic [4:0] CODE_USR = 5'h10;
	localparam logic [4:0] CODE_FIQ = 5'h11;
	localparam logic [4:0] CODE_IRQ = 5'h12;
	localparam logic [4:0] CODE_SVC = 5'h13;
	localparam logic [4:0] CODE_ABT = 5'h17;
	localparam logic [4:0] CODE_UND = 5'h1B;
	localparam logic [4:0] CODE_SYS = 5'h1F;

	localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;

	// Physical register file: r0-r15 of usr/sys, then fiq r8-r14,
	// then the r13/r14 pairs of irq, svc, abt and und.
	localparam int NumPhys    = 31;
	localparam int FiqBase    = 16;
	localparam int SpLrBase   = 23;
	localparam int NumSpsr    = 5;
	localparam logic [3:0] PcReg = 4'd15;
	localparam logic [3:0] LrReg = 4'd14;

	typedef logic [4:0] phys_idx_t;
	typedef logic [2:0] spsr_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  reg_index;
		logic [4:0]  mode_code;
		logic [31:0] data;
		logic [31:0] return_address;
	} request_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_mode;
	} result_t;

	function automatic mode_t decode_mode(input logic [4:0] code);
		mode_t m;
		unique case (code)
			CODE_USR: m = MODE_USR;
			CODE_FIQ: m = MODE_FIQ;
			CODE_IRQ: m = MODE_IRQ;
			CODE_SVC: m = MODE_SVC;
			CODE_ABT: m = MODE_ABT;
			CODE_UND: m = MODE_UND;
			CODE_SYS: m = MODE_SYS;
			default:  m = MODE_BAD;
		endcase
		return m;
	endfunction

	function automatic logic is_exc_mode(input mode_t m);
		return (m >= MODE_FIQ) && (m <= MODE_UND);
	endfunction

	function automatic phys_idx_t phys_index(input mode_t m, input logic [3:0] r);
		logic [2:0] off;
		off = 3'(m - MODE_IRQ);
		if (r >= 4'd8 && r <= 4'd14 && m == MODE_FIQ) begin
			return phys_idx_t'(FiqBase) + phys_idx_t'(r - 4'd8);
		end
		if (r >= 4'd13 && r <= 4'd14 && m >= MODE_IRQ && m <= MODE_UND) begin
			// r13 has bit 0 set, r14 clear: the pair slot is the inverted bit.
			return phys_idx_t'(SpLrBase) + phys_idx_t'({off[1:0], ~r[0]});
		end
		return phys_idx_t'(r);
	endfunction

	function automatic spsr_idx_t spsr_index(input mode_t m);
		return spsr_idx_t'(m - MODE_FIQ);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/abrf_ifs.sv -----
// Valid/ready channel interfaces for the request and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface abrf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  reg_index;
	logic [4:0]  mode_code;
	logic [31:0] data;
	logic [31:0] return_address;

	modport source (output valid, cmd, reg_index, mode_code, data, return_address,
		input ready);
	modport sink (input valid, cmd, reg_index, mode_code, data, return_address,
		output ready);
endinterface

interface abrf_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        bad_mode;

	modport source (output valid, read_data, bad_mode, input ready);
	modport sink (input valid, read_data, bad_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/abrf_regs.sv -----
// Banked register storage, status words and the combinational command execution.
`timescale 1ns / 1ps
`default_nettype none

module abrf_regs import abrf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     exec_en,
	input  wire request_t req,
	output result_t       res
);

	logic [31:0] gpr_q [NumPhys];
	logic [31:0] spsr_q [NumSpsr];
	logic [31:0] cpsr_q;
	mode_t       mode_q;

	logic        gpr_we;
	phys_idx_t   gpr_idx;
	logic        exc_en;
	phys_idx_t   lr_idx;
	logic        spsr_we;
	spsr_idx_t   spsr_widx;
	logic [31:0] spsr_wdata;
	logic        cpsr_we;
	logic [31:0] cpsr_d;
	logic        mode_we;
	mode_t       mode_d;
	mode_t       req_mode;
	mode_t       data_mode;
	mode_t       fwd_mode;

	always_comb begin
		res        = '0;
		gpr_we     = 1'b0;
		gpr_idx    = phys_index(mode_q, req.reg_index);
		exc_en     = 1'b0;
		spsr_we    = 1'b0;
		spsr_widx  = spsr_index(mode_q);
		spsr_wdata = req.data;
		cpsr_we    = 1'b0;
		cpsr_d     = req.data;
		mode_we    = 1'b0;
		req_mode   = decode_mode(req.mode_code);
		data_mode  = decode_mode(req.data[4:0]);
		mode_d     = data_mode;
		fwd_mode   = (req_mode == MODE_BAD) ? MODE_USR : req_mode;
		lr_idx     = phys_index(req_mode, LrReg);
		unique case (req.cmd)
			CMD_READ: begin
				res.read_data = gpr_q[gpr_idx];
			end
			CMD_WRITE: begin
				gpr_we = 1'b1;
			end
			CMD_WRITE_MODE: begin
				// An unknown mode code falls back to the user bank.
				gpr_we       = 1'b1;
				gpr_idx      = phys_index(fwd_mode, req.reg_index);
				res.bad_mode = (req_mode == MODE_BAD);
			end
			CMD_RD_CPSR: begin
				res.read_data = cpsr_q;
			end
			CMD_WR_CPSR: begin
				cpsr_we      = 1'b1;
				mode_we      = (data_mode != MODE_BAD);
				res.bad_mode = (data_mode == MODE_BAD);
			end
			CMD_RD_SPSR: begin
				res.read_data = is_exc_mode(mode_q) ? spsr_q[spsr_index(mode_q)] : cpsr_q;
			end
			CMD_WR_SPSR: begin
				spsr_we = is_exc_mode(mode_q);
			end
			CMD_EXCEPTION: begin
				if (is_exc_mode(req_mode)) begin
					exc_en     = 1'b1;
					spsr_we    = 1'b1;
					spsr_widx  = spsr_index(req_mode);
					spsr_wdata = cpsr_q;
					cpsr_we    = 1'b1;
					// T cleared, mode loaded, I set, F set on entry to FIQ.
					cpsr_d     = {cpsr_q[31:8], 1'b1, cpsr_q[6] | (req_mode == MODE_FIQ),
						1'b0, req.mode_code};
					mode_we    = 1'b1;
					mode_d     = req_mode;
					res.read_data = cpsr_d;
				end else begin
					res.bad_mode = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumPhys; i++) begin
				gpr_q[i] <= '0;
			end
			for (int i = 0; i < NumSpsr; i++) begin
				spsr_q[i] <= '0;
			end
			cpsr_q <= CPSR_RESET;
			mode_q <= MODE_SVC;
		end else if (exec_en) begin
			for (int i = 0; i < NumPhys; i++) begin
				if (gpr_we && gpr_idx == phys_idx_t'(i)) begin
					gpr_q[i] <= req.data;
				end
				if (exc_en && lr_idx == phys_idx_t'(i)) begin
					gpr_q[i] <= req.return_address;
				end
			end
			if (exc_en) begin
				gpr_q[phys_idx_t'(PcReg)] <= req.data;
			end
			if (spsr_we) begin
				spsr_q[spsr_widx] <= spsr_wdata;
			end
			if (cpsr_we) begin
				cpsr_q <= cpsr_d;
			end
			if (mode_we) begin
				mode_q <= mode_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/arm_banked_register_file.sv -----
// A request's result is registered when the result register is free or drains.
// Throughput: one request per cycle while results are taken; the input and result
// registers are separated by one pass of bank decode, read mux and write enables.
// Reset: asynchronous, active low; all registers and SPSRs clear, CPSR becomes 0xD3 in
// supervisor mode, both pipeline registers empty.
// Top level of the banked register file with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

module arm_banked_register_file import abrf_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	abrf_req_if.sink  req,
	abrf_rsp_if.source rsp
);

	logic     v_s1;
	request_t req_s1;
	logic     advance;
	result_t  exec_res;
	logic     rsp_valid_q;
	result_t  rsp_q;

	// The executing request moves on whenever the result register is free or drains.
	assign advance   = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.cmd            <= cmd_t'(req.cmd);
			req_s1.reg_index      <= req.reg_index;
			req_s1.mode_code      <= req.mode_code;
			req_s1.data           <= req.data;
			req_s1.return_address <= req.return_address;
		end
	end

	abrf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.exec_en (advance),
		.req     (req_s1),
		.res     (exec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= exec_res;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_q.read_data;
	assign rsp.bad_mode  = rsp_q.bad_mode;

`ifndef SYNTHESIS
	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("executed request did not reach the result register");

	a_bad_only_on_mode_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && exec_res.bad_mode) |-> (req_s1.cmd == CMD_WRITE_MODE
			|| req_s1.cmd == CMD_WR_CPSR || req_s1.cmd == CMD_EXCEPTION))
		else $error("bad_mode raised by a command that carries no mode code");

	a_writes_return_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.cmd == CMD_WRITE || req_s1.cmd == CMD_WRITE_MODE
			|| req_s1.cmd == CMD_WR_CPSR || req_s1.cmd == CMD_WR_SPSR))
		|-> (exec_res.read_data == '0))
		else $error("write command produced nonzero read data");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> req.ready)
		else $error("request refused while the input register is empty");
`endif

endmodule

`default_nettype wire
